// File: rtl/triangle_face_normal_assert.svh
// Assertion macros for the triangle face normal checker.
// Expects signals named clock and reset in the scope of each use.
`ifndef TRIANGLE_FACE_NORMAL_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define TFN_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define TFN_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: rtl/tfn_pkg.sv
// Shared constants for the triangle face normal block.
// No dependencies.
`default_nettype none
package tfn_pkg;
   localparam int COORD_BITS_DEF       = 16;
   localparam int NORMAL_FRAC_BITS_DEF = 14;
endpackage
`default_nettype wire

// File: rtl/tfn_req_if.sv
// Triangle request channel: valid/ready plus three vertices.
// Depends on tfn_pkg for the default coordinate width.
`default_nettype none
interface tfn_req_if #(parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] ax;
   logic signed [COORD_BITS-1:0] ay;
   logic signed [COORD_BITS-1:0] az;
   logic signed [COORD_BITS-1:0] bx;
   logic signed [COORD_BITS-1:0] by_coord;
   logic signed [COORD_BITS-1:0] bz;
   logic signed [COORD_BITS-1:0] cx;
   logic signed [COORD_BITS-1:0] cy;
   logic signed [COORD_BITS-1:0] cz;

   modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, input ready);
   modport sink   (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, output ready);
endinterface

// Normal response channel: valid/ready plus unit normal and flag.
interface tfn_rsp_if #(parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF);
   logic                               valid;
   logic                               ready;
   logic signed [NORMAL_FRAC_BITS+1:0] nx;
   logic signed [NORMAL_FRAC_BITS+1:0] ny;
   logic signed [NORMAL_FRAC_BITS+1:0] nz;
   logic                               degenerate;

   modport source (output valid, nx, ny, nz, degenerate, input ready);
   modport sink   (input valid, nx, ny, nz, degenerate, output ready);
endinterface
`default_nettype wire

// File: rtl/triangle_face_normal.sv
// Top level of the triangle face normal pipeline.
// Depends on tfn_pkg and the channel interfaces in tfn_req_if.sv.
`default_nettype none
// Accepts one triangle per clock and returns its unit face normal in signed
// Q1.F (F = NORMAL_FRAC_BITS), rounded to nearest with halves away from zero.
// Pipeline stages: edge subtract, edge products, cross difference, squares,
// length setup, then one stage per result bit (F+1 stages) that settles
// that bit of all three components with an exact shift-add compare against
// the squared length, then an output register. Throughput is one beat per
// cycle; when the response side stalls, the whole pipeline holds and req
// ready drops in the same cycle. A triangle whose cross product is the zero
// vector returns zero components with degenerate set.
module triangle_face_normal #(
   parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tfn_req_if.sink     req_ch,
   tfn_rsp_if.source   rsp_ch
);
   localparam int CB   = COORD_BITS;
   localparam int F    = NORMAL_FRAC_BITS;
   localparam int EW   = CB + 1;          // edge vector component
   localparam int PW   = 2 * EW;          // edge product
   localparam int NW   = PW + 1;          // cross product component
   localparam int QW   = 2 * NW;          // squared component
   localparam int SW   = QW + 2;          // squared length
   localparam int AW   = SW + 2 * F + 5;  // compare accumulators
   localparam int OW   = F + 2;           // result component
   localparam int QB   = F + 1;           // result magnitude
   localparam int NSTG = F + 1;           // one stage per magnitude bit

   // Global advance: the pipeline moves whenever the output slot frees up.
   logic en;
   logic v_o_ff;
   assign en           = ~v_o_ff | rsp_ch.ready;
   assign req_ch.ready = en;

   // Stage 1: edge vectors e1 = B - A, e2 = C - A (x, y, z order).
   logic                 v_e_ff;
   logic signed [EW-1:0] e_in [6];
   logic signed [EW-1:0] e_ff [6];
   assign e_in[0] = EW'(req_ch.bx)       - EW'(req_ch.ax);
   assign e_in[1] = EW'(req_ch.by_coord) - EW'(req_ch.ay);
   assign e_in[2] = EW'(req_ch.bz)       - EW'(req_ch.az);
   assign e_in[3] = EW'(req_ch.cx)       - EW'(req_ch.ax);
   assign e_in[4] = EW'(req_ch.cy)       - EW'(req_ch.ay);
   assign e_in[5] = EW'(req_ch.cz)       - EW'(req_ch.az);

   // Stage 2: the six cross product terms, paired per component.
   logic                 v_p_ff;
   logic signed [PW-1:0] p_in [6];
   logic signed [PW-1:0] p_ff [6];
   assign p_in[0] = e_ff[1] * e_ff[5];   // e1y*e2z
   assign p_in[1] = e_ff[4] * e_ff[2];   // e2y*e1z
   assign p_in[2] = e_ff[3] * e_ff[2];   // e2x*e1z
   assign p_in[3] = e_ff[0] * e_ff[5];   // e1x*e2z
   assign p_in[4] = e_ff[0] * e_ff[4];   // e1x*e2y
   assign p_in[5] = e_ff[3] * e_ff[1];   // e2x*e1y

   // Stage 3: cross product N.
   logic                 v_n_ff;
   logic signed [NW-1:0] n_in [3];
   logic signed [NW-1:0] n_ff [3];

   // Stage 4: squared components plus signs.
   logic                 v_q_ff;
   logic        [QW-1:0] sq_in [3];
   logic        [QW-1:0] sq_ff [3];
   logic                 neg_q_ff [3];

   for (genvar c = 0; c < 3; c++) begin : g_cross
      assign n_in[c]  = NW'(p_ff[2*c]) - NW'(p_ff[2*c+1]);
      assign sq_in[c] = QW'(n_ff[c] * n_ff[c]);
   end

   // Iteration stages. Index 0 is the setup stage; index k+1 holds the state
   // after magnitude bit F-k is settled. Per component:
   //   a = u*u*s, b = u*s with u = 2q-1, r = |N_i|^2 * 2^(2F+2);
   // bit b of q is kept when (2q'-1)^2 * s <= r for the trial q'.
   logic                 v_it_ff  [NSTG+1];
   logic signed [AW-1:0] a_ff     [NSTG+1][3];
   logic signed [AW-1:0] b_ff     [NSTG+1][3];
   logic signed [AW-1:0] r_ff     [NSTG+1][3];
   logic        [QB-1:0] q_ff     [NSTG+1][3];
   logic                 neg_ff   [NSTG+1][3];
   logic signed [AW-1:0] s_ff     [NSTG+1];
   logic                 degen_ff [NSTG+1];

   logic        [SW-1:0] s_in;
   logic signed [AW-1:0] s_ext;
   assign s_in  = SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
   assign s_ext = AW'(s_in);

   // Valid bits: clear on reset, advance with the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_e_ff <= 1'b0;
         v_p_ff <= 1'b0;
         v_n_ff <= 1'b0;
         v_q_ff <= 1'b0;
         for (int k = 0; k <= NSTG; k++) v_it_ff[k] <= 1'b0;
         v_o_ff <= 1'b0;
      end else if (en) begin
         v_e_ff     <= req_ch.valid;
         v_p_ff     <= v_e_ff;
         v_n_ff     <= v_p_ff;
         v_q_ff     <= v_n_ff;
         v_it_ff[0] <= v_q_ff;
         for (int k = 0; k < NSTG; k++) v_it_ff[k+1] <= v_it_ff[k];
         v_o_ff     <= v_it_ff[NSTG];
      end
   end

   // Front stages and setup: hold on stall, advance otherwise.
   always_ff @(posedge clock) begin
      if (en) begin
         e_ff <= e_in;
         p_ff <= p_in;
         n_ff <= n_in;
         for (int c = 0; c < 3; c++) begin
            sq_ff[c]     <= sq_in[c];
            neg_q_ff[c]  <= n_ff[c][NW-1];
            a_ff[0][c]   <= s_ext;
            b_ff[0][c]   <= -s_ext;
            r_ff[0][c]   <= AW'(sq_ff[c]) << (2 * F + 2);
            q_ff[0][c]   <= '0;
            neg_ff[0][c] <= neg_q_ff[c];
         end
         s_ff[0]     <= s_ext;
         degen_ff[0] <= (s_in == '0);
      end
   end

   for (genvar k = 0; k < NSTG; k++) begin : g_bit
      localparam int BIT = F - k;
      always_ff @(posedge clock) begin
         if (en) begin
            s_ff[k+1]     <= s_ff[k];
            degen_ff[k+1] <= degen_ff[k];
         end
      end
      for (genvar c = 0; c < 3; c++) begin : g_comp
         logic signed [AW-1:0] cand;
         logic                 take;
         assign cand = a_ff[k][c] + (b_ff[k][c] <<< (BIT + 2)) + (s_ff[k] <<< (2 * BIT + 2));
         assign take = (cand <= r_ff[k][c]);
         always_ff @(posedge clock) begin
            if (en) begin
               a_ff[k+1][c]   <= take ? cand : a_ff[k][c];
               b_ff[k+1][c]   <= take ? (b_ff[k][c] + (s_ff[k] <<< (BIT + 1))) : b_ff[k][c];
               q_ff[k+1][c]   <= q_ff[k][c] | (take ? (QB'(1) << BIT) : QB'(0));
               r_ff[k+1][c]   <= r_ff[k][c];
               neg_ff[k+1][c] <= neg_ff[k][c];
            end
         end
      end
   end

   // Output register: apply sign, zero out a degenerate triangle.
   logic signed [OW-1:0] o_in [3];
   logic signed [OW-1:0] o_ff [3];
   logic                 degen_o_ff;
   for (genvar c = 0; c < 3; c++) begin : g_out
      logic signed [OW-1:0] mag;
      assign mag     = OW'(q_ff[NSTG][c]);
      assign o_in[c] = degen_ff[NSTG] ? OW'(0) : (neg_ff[NSTG][c] ? -mag : mag);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_ff       <= o_in;
         degen_o_ff <= degen_ff[NSTG];
      end
   end

   assign rsp_ch.valid      = v_o_ff;
   assign rsp_ch.nx         = o_ff[0];
   assign rsp_ch.ny         = o_ff[1];
   assign rsp_ch.nz         = o_ff[2];
   assign rsp_ch.degenerate = degen_o_ff;
endmodule
`default_nettype wire

// File: rtl/tfn_checker.sv
// Port-level checks for the triangle face normal block, bound to the top.
// Depends on tfn_pkg and triangle_face_normal_assert.svh.
`default_nettype none
`include "triangle_face_normal_assert.svh"
module tfn_checker #(
   parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [NORMAL_FRAC_BITS+1:0] nx,
   input wire logic signed [NORMAL_FRAC_BITS+1:0] ny,
   input wire logic signed [NORMAL_FRAC_BITS+1:0] nz,
   input wire logic                               degenerate
);
   localparam logic signed [NORMAL_FRAC_BITS+1:0] LIM =
      (NORMAL_FRAC_BITS+2)'(1) << NORMAL_FRAC_BITS;
   localparam logic signed [NORMAL_FRAC_BITS+1:0] NLIM = -LIM;

   // Input side takes a beat exactly when the output slot can move.
   `TFN_ASSERT_ALWAYS(a_ready_law, req_ready == (!rsp_valid || rsp_ready), "ready mismatch")
   // Stalled result holds.
   `TFN_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(nx) && $stable(ny) && $stable(nz) && $stable(degenerate), "stalled beat changed")
   // Degenerate beats carry zero components.
   `TFN_ASSERT_ALWAYS(a_degen_zero, !(rsp_valid && degenerate) || (nx == 0 && ny == 0 && nz == 0), "degenerate beat not zero")
   // Unit components never exceed one.
   `TFN_ASSERT_ALWAYS(a_unit_range, !rsp_valid || (nx >= NLIM && nx <= LIM && ny >= NLIM && ny <= LIM && nz >= NLIM && nz <= LIM), "component out of range")
endmodule

bind triangle_face_normal tfn_checker #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_tfn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .nx         (rsp_ch.nx),
   .ny         (rsp_ch.ny),
   .nz         (rsp_ch.nz),
   .degenerate (rsp_ch.degenerate)
);
`default_nettype wire
